>>> src/ktga_pkg.sv
package ktga_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int ADC_W       = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W     = 12;
  localparam int PAT_W       = 8;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_GAS  = 2'd1,
    ACT_RUN  = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REP_NONE    = 2'd0,
    REP_GAS_ON  = 2'd1,
    REP_GAS_OFF = 2'd2,
    REP_STOPPED = 2'd3
  } report_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COUNT   = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_GAS     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH_1 = 3'd0,
    REG_THRESH_2 = 3'd1,
    REG_THRESH_3 = 3'd2,
    REG_THRESH_4 = 3'd3,
    REG_THRESH_5 = 3'd4,
    REG_UNIT     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] thresh_1;
    logic [CFG_W-1:0] thresh_2;
    logic [CFG_W-1:0] thresh_3;
    logic [CFG_W-1:0] thresh_4;
    logic [CFG_W-1:0] thresh_5;
    logic [CFG_W-1:0] unit;
  } cfg_t;

  typedef struct packed {
    logic               buzzer;
    logic               lamp_run;
    logic               lamp_gas;
    logic               tick_fast;
    logic               tick_on;
    logic               beep_pulse;
    report_t            report;
    mode_t              mode;
    logic [COUNT_W-1:0] remaining;
  } result_t;

endpackage

>>> src/knob_timer_gas_alarm_controller.sv
// Appliance reminder controller. Each input transaction carries one event (timer tick, gas
// onset, run press or stop press) and produces exactly one output transaction holding the
// lamp and buzzer levels, tick settings, beep request, report code, mode and remaining count.
// An event is captured in an input register and evaluated against the controller state into
// the output register, so the block takes one transaction per clock while the output is not
// stalled; the state update of one event feeding the next sets that rate. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must do so only
// while idle, as the block itself does not enforce it.
module knob_timer_gas_alarm_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ktga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ktga_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [ktga_pkg::ADC_W-1:0]     adc_sample,
  input  logic                           gas_present,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           buzzer,
  output logic                           lamp_run,
  output logic                           lamp_gas,
  output logic                           tick_fast,
  output logic                           tick_on,
  output logic                           beep_pulse,
  output logic [1:0]                     report,
  output logic [1:0]                     mode,
  output logic [ktga_pkg::COUNT_W-1:0]   remaining
);
  import ktga_pkg::*;

  cfg_t             cfg;
  result_t          result;
  result_t          out_res;
  logic             s1_valid;
  logic [1:0]       s1_action;
  logic [ADC_W-1:0] s1_sample;
  logic             s1_present;
  logic             advance;
  logic             load;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  ktga_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ktga_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .action      (s1_action),
    .adc_sample  (s1_sample),
    .gas_present (s1_present),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_action  <= action;
      s1_sample  <= adc_sample;
      s1_present <= gas_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign buzzer     = out_res.buzzer;
  assign lamp_run   = out_res.lamp_run;
  assign lamp_gas   = out_res.lamp_gas;
  assign tick_fast  = out_res.tick_fast;
  assign tick_on    = out_res.tick_on;
  assign beep_pulse = out_res.beep_pulse;
  assign report     = out_res.report;
  assign mode       = out_res.mode;
  assign remaining  = out_res.remaining;

endmodule

>>> src/ktga_cfg.sv
module ktga_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ktga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ktga_pkg::CFG_W-1:0]     cfg_data,
  output ktga_pkg::cfg_t                 cfg
);
  import ktga_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh_1 <= CFG_W'(170);
      cfg.thresh_2 <= CFG_W'(326);
      cfg.thresh_3 <= CFG_W'(476);
      cfg.thresh_4 <= CFG_W'(675);
      cfg.thresh_5 <= CFG_W'(821);
      cfg.unit     <= CFG_W'(600);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESH_1: cfg.thresh_1 <= cfg_data;
        REG_THRESH_2: cfg.thresh_2 <= cfg_data;
        REG_THRESH_3: cfg.thresh_3 <= cfg_data;
        REG_THRESH_4: cfg.thresh_4 <= cfg_data;
        REG_THRESH_5: cfg.thresh_5 <= cfg_data;
        REG_UNIT:     cfg.unit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/ktga_step.sv
module ktga_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [1:0]                 action,
  input  logic [ktga_pkg::ADC_W-1:0] adc_sample,
  input  logic                       gas_present,
  input  ktga_pkg::cfg_t             cfg,
  output ktga_pkg::result_t          result
);
  import ktga_pkg::*;

  typedef struct packed {
    logic               timeout_active;
    logic               gas_active;
    logic               run_active;
    logic               ticks_enabled;
    logic               run_button_enabled;
    logic               report_pending;
    logic               fast_select;
    logic [COUNT_W-1:0] preset_ticks;
    logic [COUNT_W-1:0] countdown;
    logic [PAT_W-1:0]   pattern_count;
    logic               buz;
    logic               run_lamp;
    logic               gas_lamp;
  } state_t;

  localparam logic [ADC_W-1:0] SampleMask = ADC_W'((1 << SAMPLE_BITS) - 1);

  state_t  st;
  state_t  st_next;
  state_t  st_reset;

  function automatic state_t timeout_pattern(input state_t s);
    state_t r;
    r = s;
    if (s.pattern_count < PAT_W'(4)) begin
      r.run_lamp = 1'b1;
      r.buz      = 1'b1;
    end else if (s.pattern_count < PAT_W'(7))  r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(10)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(13)) r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(16)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(19)) r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(22)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(25)) r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(28)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(36)) r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(38)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(41)) r.buz = 1'b0;
    else if (s.pattern_count < PAT_W'(49)) r.buz = 1'b1;
    else if (s.pattern_count < PAT_W'(81)) r.buz = 1'b0;
    else r.pattern_count = '0;
    return r;
  endfunction

  function automatic state_t gas_pattern(input state_t s, input logic present,
                                         input logic may_report, input report_t rep_i,
                                         output report_t rep_o);
    state_t r;
    r     = s;
    rep_o = rep_i;
    r.run_button_enabled = 1'b0;
    if (present) begin
      if (s.pattern_count == PAT_W'(2)) begin
        r.gas_lamp      = ~s.gas_lamp;
        r.buz           = ~s.buz;
        r.pattern_count = '0;
      end
    end else begin
      if (s.report_pending && may_report) begin
        rep_o            = REP_GAS_OFF;
        r.report_pending = 1'b0;
      end
      if (s.pattern_count < PAT_W'(6)) begin
        r.gas_lamp = 1'b1;
        r.buz      = 1'b1;
      end else if (s.pattern_count < PAT_W'(7))  r.buz = 1'b0;
      else if (s.pattern_count < PAT_W'(13)) r.buz = 1'b1;
      else if (s.pattern_count < PAT_W'(63)) r.buz = 1'b0;
      else r.pattern_count = '0;
    end
    return r;
  endfunction

  function automatic state_t alarm_step(input state_t s, input logic present,
                                        input logic may_report, input report_t rep_i,
                                        output report_t rep_o);
    state_t r;
    r     = s;
    rep_o = rep_i;
    if (s.timeout_active) r = timeout_pattern(s);
    else if (s.gas_active) r = gas_pattern(s, present, may_report, rep_i, rep_o);
    return r;
  endfunction

  logic [ADC_W-1:0]   sample;
  logic [2:0]         units;
  logic [COUNT_W-1:0] want;
  logic               beep;
  report_t            rep;
  report_t            rep_a;
  mode_t              mode;

  assign sample = adc_sample & SampleMask;

  always_comb begin
    priority if (sample < cfg.thresh_1) units = 3'd6;
    else if (sample < cfg.thresh_2) units = 3'd5;
    else if (sample < cfg.thresh_3) units = 3'd4;
    else if (sample < cfg.thresh_4) units = 3'd3;
    else if (sample < cfg.thresh_5) units = 3'd2;
    else units = 3'd1;
  end

  assign want = COUNT_W'(units) * COUNT_W'(cfg.unit);

  always_comb begin
    st_next = st;
    beep    = 1'b0;
    rep     = REP_NONE;
    rep_a   = REP_NONE;
    unique case (action_t'(action))
      ACT_TICK: begin
        if (st.ticks_enabled) begin
          if (st.timeout_active || st.gas_active) begin
            st_next.pattern_count = st.pattern_count + PAT_W'(1);
            st_next = alarm_step(st_next, gas_present, 1'b1, rep, rep_a);
            rep     = rep_a;
          end else begin
            if (st.preset_ticks == want) begin
              if (st.countdown != '0) st_next.countdown = st.countdown - COUNT_W'(1);
              if (st_next.countdown == '0) begin
                st_next.timeout_active = 1'b1;
                st_next.fast_select    = 1'b1;
                st_next.pattern_count  = '0;
              end
            end else begin
              st_next.preset_ticks = want;
              st_next.countdown    = want;
              beep                 = 1'b1;
              st_next.buz          = 1'b0;
            end
            st_next.run_lamp = ~st_next.run_lamp;
            if (st_next.timeout_active) begin
              st_next = alarm_step(st_next, gas_present, 1'b1, rep, rep_a);
              rep     = rep_a;
            end
          end
        end
      end
      ACT_GAS: begin
        st_next.gas_active     = 1'b1;
        st_next.timeout_active = 1'b0;
        st_next.ticks_enabled  = 1'b1;
        st_next.fast_select    = 1'b1;
        st_next.pattern_count  = '0;
        st_next.report_pending = 1'b1;
        rep                    = REP_GAS_ON;
        st_next = alarm_step(st_next, gas_present, 1'b0, rep, rep_a);
        rep     = rep_a;
      end
      ACT_RUN: begin
        if (st.run_button_enabled) begin
          st_next.run_active     = 1'b1;
          st_next.run_lamp       = 1'b1;
          st_next.preset_ticks   = '0;
          st_next.ticks_enabled  = 1'b1;
          st_next.timeout_active = 1'b0;
          st_next.fast_select    = 1'b0;
          st_next = alarm_step(st_next, gas_present, 1'b1, rep, rep_a);
          rep     = rep_a;
        end
      end
      ACT_STOP: begin
        beep                       = 1'b1;
        st_next.buz                = 1'b0;
        st_next.run_lamp           = 1'b0;
        st_next.gas_lamp           = 1'b0;
        st_next.gas_active         = 1'b0;
        st_next.timeout_active     = 1'b0;
        st_next.run_active         = 1'b0;
        st_next.ticks_enabled      = 1'b0;
        st_next.run_button_enabled = 1'b1;
        rep                        = REP_STOPPED;
      end
    endcase
  end

  always_comb begin
    priority if (st_next.timeout_active) mode = MODE_TIMEOUT;
    else if (st_next.gas_active) mode = MODE_GAS;
    else if (st_next.run_active) mode = MODE_COUNT;
    else mode = MODE_IDLE;
  end

  always_comb begin
    result.buzzer     = st_next.buz;
    result.lamp_run   = st_next.run_lamp;
    result.lamp_gas   = st_next.gas_lamp;
    result.tick_fast  = st_next.fast_select;
    result.tick_on    = st_next.ticks_enabled;
    result.beep_pulse = beep;
    result.report     = rep;
    result.mode       = mode;
    result.remaining  = st_next.countdown;
  end

  always_comb begin
    st_reset                    = '0;
    st_reset.run_button_enabled = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ktga_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_TICK;
  logic [ADC_W-1:0]     adc_sample = '0;
  logic                 gas_present = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 buzzer;
  logic                 lamp_run;
  logic                 lamp_gas;
  logic                 tick_fast;
  logic                 tick_on;
  logic                 beep_pulse;
  logic [1:0]           report;
  logic [1:0]           mode;
  logic [COUNT_W-1:0]   remaining;

  // Controller state as predicted from the accepted transactions.
  logic [CFG_W-1:0]   thr [5];
  logic [CFG_W-1:0]   unit_ticks;
  logic               alarm_timeout;
  logic               alarm_gas;
  logic               run_on;
  logic               ticks_on;
  logic               run_unlocked;
  logic               clear_report_due;
  logic               fast_ticks;
  logic [COUNT_W-1:0] armed_ticks;
  logic [COUNT_W-1:0] count_left;
  logic [PAT_W-1:0]   pat_cnt;
  logic               buz;
  logic               run_lamp;
  logic               gas_lamp;

  result_t panel_states[$];
  int      sent_items = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  logic    calm = 1'b0;
  logic    hold_active = 1'b0;
  event    hold_off_start;

  knob_timer_gas_alarm_controller u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .adc_sample  (adc_sample),
    .gas_present (gas_present),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buzzer      (buzzer),
    .lamp_run    (lamp_run),
    .lamp_gas    (lamp_gas),
    .tick_fast   (tick_fast),
    .tick_on     (tick_on),
    .beep_pulse  (beep_pulse),
    .report      (report),
    .mode        (mode),
    .remaining   (remaining)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("knob_timer_gas_alarm_controller verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  task automatic reset_controller();
    thr[0] = 10'd170;
    thr[1] = 10'd326;
    thr[2] = 10'd476;
    thr[3] = 10'd675;
    thr[4] = 10'd821;
    unit_ticks = 10'd600;
    alarm_timeout = 1'b0;
    alarm_gas = 1'b0;
    run_on = 1'b0;
    ticks_on = 1'b0;
    run_unlocked = 1'b1;
    clear_report_due = 1'b0;
    fast_ticks = 1'b0;
    armed_ticks = '0;
    count_left = '0;
    pat_cnt = '0;
    buz = 1'b0;
    run_lamp = 1'b0;
    gas_lamp = 1'b0;
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_THRESH_1: thr[0] = val;
      REG_THRESH_2: thr[1] = val;
      REG_THRESH_3: thr[2] = val;
      REG_THRESH_4: thr[3] = val;
      REG_THRESH_5: thr[4] = val;
      REG_UNIT:     unit_ticks = val;
      default: ;
    endcase
  endtask

  function automatic logic [COUNT_W-1:0] knob_ticks(logic [ADC_W-1:0] smp);
    logic [2:0]  units;
    logic [12:0] product;
    if (smp < thr[0]) units = 3'd6;
    else if (smp < thr[1]) units = 3'd5;
    else if (smp < thr[2]) units = 3'd4;
    else if (smp < thr[3]) units = 3'd3;
    else if (smp < thr[4]) units = 3'd2;
    else units = 3'd1;
    product = 13'(units) * 13'(unit_ticks);
    return product[COUNT_W-1:0];
  endfunction

  task automatic timeout_step();
    if (pat_cnt < 4) begin
      run_lamp = 1'b1;
      buz = 1'b1;
    end
    else if (pat_cnt < 7) buz = 1'b0;
    else if (pat_cnt < 10) buz = 1'b1;
    else if (pat_cnt < 13) buz = 1'b0;
    else if (pat_cnt < 16) buz = 1'b1;
    else if (pat_cnt < 19) buz = 1'b0;
    else if (pat_cnt < 22) buz = 1'b1;
    else if (pat_cnt < 25) buz = 1'b0;
    else if (pat_cnt < 28) buz = 1'b1;
    else if (pat_cnt < 36) buz = 1'b0;
    else if (pat_cnt < 38) buz = 1'b1;
    else if (pat_cnt < 41) buz = 1'b0;
    else if (pat_cnt < 49) buz = 1'b1;
    else if (pat_cnt < 81) buz = 1'b0;
    else pat_cnt = '0;
  endtask

  task automatic gas_step(logic gp, logic may_report, inout report_t rep);
    run_unlocked = 1'b0;
    if (gp) begin
      if (pat_cnt == 2) begin
        gas_lamp = ~gas_lamp;
        buz = ~buz;
        pat_cnt = '0;
      end
    end else begin
      if (clear_report_due && may_report) begin
        rep = REP_GAS_OFF;
        clear_report_due = 1'b0;
      end
      if (pat_cnt < 6) begin
        gas_lamp = 1'b1;
        buz = 1'b1;
      end
      else if (pat_cnt < 7) buz = 1'b0;
      else if (pat_cnt < 13) buz = 1'b1;
      else if (pat_cnt < 63) buz = 1'b0;
      else pat_cnt = '0;
    end
  endtask

  task automatic alarm_step(logic gp, logic may_report, inout report_t rep);
    if (alarm_timeout) timeout_step();
    else if (alarm_gas) gas_step(gp, may_report, rep);
  endtask

  task automatic step_controller(logic [1:0] act, logic [ADC_W-1:0] smp, logic gp);
    result_t            r;
    report_t            rep;
    logic [COUNT_W-1:0] want;
    logic               beep;
    rep = REP_NONE;
    beep = 1'b0;
    case (act)
      ACT_TICK: begin
        if (ticks_on) begin
          if (alarm_timeout || alarm_gas) begin
            pat_cnt = pat_cnt + 1'b1;
            alarm_step(gp, 1'b1, rep);
          end else begin
            want = knob_ticks(smp);
            if (armed_ticks == want) begin
              if (count_left != 0) count_left = count_left - 1'b1;
              if (count_left == 0) begin
                alarm_timeout = 1'b1;
                fast_ticks = 1'b1;
                pat_cnt = '0;
              end
            end else begin
              armed_ticks = want;
              count_left = want;
              beep = 1'b1;
              buz = 1'b0;
            end
            run_lamp = ~run_lamp;
            if (alarm_timeout) alarm_step(gp, 1'b1, rep);
          end
        end
      end
      ACT_GAS: begin
        alarm_gas = 1'b1;
        alarm_timeout = 1'b0;
        ticks_on = 1'b1;
        fast_ticks = 1'b1;
        pat_cnt = '0;
        rep = REP_GAS_ON;
        clear_report_due = 1'b1;
        alarm_step(gp, 1'b0, rep);
      end
      ACT_RUN: begin
        if (run_unlocked) begin
          run_on = 1'b1;
          run_lamp = 1'b1;
          armed_ticks = '0;
          ticks_on = 1'b1;
          alarm_timeout = 1'b0;
          fast_ticks = 1'b0;
          alarm_step(gp, 1'b1, rep);
        end
      end
      default: begin
        beep = 1'b1;
        buz = 1'b0;
        run_lamp = 1'b0;
        gas_lamp = 1'b0;
        alarm_gas = 1'b0;
        alarm_timeout = 1'b0;
        run_on = 1'b0;
        ticks_on = 1'b0;
        run_unlocked = 1'b1;
        rep = REP_STOPPED;
      end
    endcase
    r.buzzer = buz;
    r.lamp_run = run_lamp;
    r.lamp_gas = gas_lamp;
    r.tick_fast = fast_ticks;
    r.tick_on = ticks_on;
    r.beep_pulse = beep;
    r.report = rep;
    if (alarm_timeout) r.mode = MODE_TIMEOUT;
    else if (alarm_gas) r.mode = MODE_GAS;
    else if (run_on) r.mode = MODE_COUNT;
    else r.mode = MODE_IDLE;
    r.remaining = count_left;
    panel_states.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_controller();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) step_controller(action, adc_sample, gas_present);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (panel_states.size() == 0) begin
        $display("%0t ns: output transaction with no input outstanding", $time);
        mismatches++;
      end else begin
        want = panel_states.pop_front();
        check_field("buzzer", COUNT_W'(want.buzzer), COUNT_W'(buzzer));
        check_field("lamp_run", COUNT_W'(want.lamp_run), COUNT_W'(lamp_run));
        check_field("lamp_gas", COUNT_W'(want.lamp_gas), COUNT_W'(lamp_gas));
        check_field("tick_fast", COUNT_W'(want.tick_fast), COUNT_W'(tick_fast));
        check_field("tick_on", COUNT_W'(want.tick_on), COUNT_W'(tick_on));
        check_field("beep_pulse", COUNT_W'(want.beep_pulse), COUNT_W'(beep_pulse));
        check_field("report", COUNT_W'(want.report), COUNT_W'(report));
        check_field("mode", COUNT_W'(want.mode), COUNT_W'(mode));
        check_field("remaining", want.remaining, remaining);
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_active) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 6);
  end

  initial begin
    forever begin
      @(hold_off_start);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [ADC_W-1:0] any_sample();
    return ADC_W'($urandom_range(1023));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_event(action_t act, logic [ADC_W-1:0] smp, logic gp);
    if (!calm && $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    adc_sample <= smp;
    gas_present <= gp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (panel_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(logic [CFG_W-1:0] t1, logic [CFG_W-1:0] t2,
                             logic [CFG_W-1:0] t3, logic [CFG_W-1:0] t4,
                             logic [CFG_W-1:0] t5, logic [CFG_W-1:0] unit);
    reg_index_t       idx [6] = '{REG_THRESH_1, REG_THRESH_2, REG_THRESH_3,
                                  REG_THRESH_4, REG_THRESH_5, REG_UNIT};
    logic [CFG_W-1:0] vals [6];
    vals = '{t1, t2, t3, t4, t5, unit};
    settle();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic countdown_episode();
    logic [ADC_W-1:0] smp;
    int               span;
    send_event(ACT_RUN, any_sample(), any_bit());
    smp = any_sample();
    span = (unit_ticks <= 8) ? 6 * unit_ticks + 3 : $urandom_range(3, 30);
    repeat (span) begin
      if ($urandom_range(19) == 0) smp = any_sample();
      send_event(ACT_TICK, smp, any_bit());
    end
    repeat ($urandom_range(0, 100)) begin
      send_event(ACT_TICK, any_sample(), any_bit());
    end
    case ($urandom_range(3))
      0: send_event(ACT_STOP, any_sample(), any_bit());
      1: send_event(ACT_RUN, any_sample(), any_bit());
      2: send_event(ACT_GAS, any_sample(), any_bit());
      default: ;
    endcase
  endtask

  task automatic gas_episode();
    send_event(ACT_GAS, any_sample(), any_bit());
    repeat ($urandom_range(0, 12)) send_event(ACT_TICK, any_sample(), 1'b1);
    if ($urandom_range(3) == 0) send_event(ACT_RUN, any_sample(), any_bit());
    repeat ($urandom_range(0, 70)) begin
      send_event(ACT_TICK, any_sample(), $urandom_range(9) == 0);
    end
    if ($urandom_range(2) != 0) send_event(ACT_STOP, any_sample(), any_bit());
    else send_event(ACT_GAS, any_sample(), any_bit());
  endtask

  task automatic noise_episode();
    repeat ($urandom_range(3, 12)) begin
      send_event(action_t'(2'($urandom_range(3))), any_sample(), any_bit());
    end
  endtask

  task automatic random_registers();
    logic [CFG_W-1:0] t [5];
    logic [CFG_W-1:0] unit;
    case ($urandom_range(5))
      2: foreach (t[i]) t[i] = CFG_W'($urandom_range(1023));
      3: foreach (t[i]) t[i] = '0;
      4: foreach (t[i]) t[i] = '1;
      default: begin
        t[0] = CFG_W'($urandom_range(300));
        for (int i = 1; i < 5; i++) t[i] = t[i-1] + CFG_W'($urandom_range(180));
      end
    endcase
    case ($urandom_range(9))
      0: unit = '0;
      1: unit = 10'd682;
      2: unit = 10'd1;
      default: unit = CFG_W'($urandom_range(1, 5));
    endcase
    load_config(t[0], t[1], t[2], t[3], t[4], unit);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_event(ACT_TICK, 10'd1023, 1'b1);
    send_event(ACT_RUN, 10'd0, 1'b0);
    send_event(ACT_TICK, 10'd0, 1'b0);
    send_event(ACT_TICK, 10'd0, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b1);
    send_event(ACT_RUN, 10'd1023, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b0);
    send_event(ACT_STOP, 10'd0, 1'b0);
    load_config(10'd170, 10'd326, 10'd476, 10'd675, 10'd821, 10'd1);
    send_event(ACT_RUN, 10'd0, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b1);
    // A run press in the timeout alarm leaves the buzzer where it was.
    send_event(ACT_RUN, 10'd1023, 1'b0);
    send_event(ACT_TICK, 10'd1023, 1'b0);
    send_event(ACT_STOP, 10'd1023, 1'b0);
    load_config(10'd170, 10'd326, 10'd476, 10'd675, 10'd821, 10'd0);
    send_event(ACT_RUN, 10'd512, 1'b0);
    send_event(ACT_TICK, 10'd512, 1'b0);
    send_event(ACT_RUN, 10'd512, 1'b0);
    send_event(ACT_TICK, 10'd512, 1'b0);
    // Gas onset while the sensor already reads clear.
    send_event(ACT_GAS, 10'd300, 1'b0);
    send_event(ACT_TICK, 10'd300, 1'b0);
    send_event(ACT_RUN, 10'd300, 1'b0);
    send_event(ACT_TICK, 10'd300, 1'b1);
    send_event(ACT_STOP, 10'd300, 1'b1);
    send_event(ACT_GAS, 10'd700, 1'b1);
    send_event(ACT_TICK, 10'd700, 1'b1);
    send_event(ACT_TICK, 10'd700, 1'b1);
    send_event(ACT_STOP, 10'd700, 1'b1);
  endtask

  task automatic test_register_extremes();
    load_config('0, '0, '0, '0, '0, 10'd682);
    countdown_episode();
    load_config('1, '1, '1, '1, '1, 10'd1);
    countdown_episode();
    gas_episode();
    load_config(10'd1023, 10'd800, 10'd600, 10'd400, 10'd0, 10'd682);
    noise_episode();
    countdown_episode();
  endtask

  // The receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    load_config(10'd170, 10'd326, 10'd476, 10'd675, 10'd821, 10'd2);
    calm = 1'b1;
    -> hold_off_start;
    countdown_episode();
    gas_episode();
    calm = 1'b0;
  endtask

  task automatic test_calm_stream();
    load_config(10'd100, 10'd300, 10'd500, 10'd700, 10'd900, 10'd3);
    calm = 1'b1;
    repeat (3) begin
      countdown_episode();
      gas_episode();
    end
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    while (sent_items < ITEM_TARGET) begin
      random_registers();
      repeat ($urandom_range(2, 6)) begin
        case ($urandom_range(3))
          0, 1: countdown_episode();
          2: gas_episode();
          default: noise_episode();
        endcase
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_calm_stream();
    test_random_phases();
    settle();
    if (mismatches == 0) begin
      $display("knob_timer_gas_alarm_controller verification clean");
    end else begin
      $display("knob_timer_gas_alarm_controller verification failed");
    end
    $finish;
  end

endmodule
